### rtl/core/mandel_pkg.sv
// Shared types and constants for the Mandelbrot escape-time pixel block.
// Holds field widths, reset values, register indexes and state encodings.
// Depends on nothing; compile it first.
package mandel_pkg;

  // Fixed widths of the item fields and the configuration port.
  localparam int COORD_W    = 16;
  localparam int CNT_W      = 10;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Default fixed-point fraction bits and front-to-back queue depth.
  localparam int FRAC_BITS_DEF   = 28;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Multiplier operand slice taken from the second factor per cycle.
  localparam int MUL_DIGIT = 17;

  // Register reset values.
  localparam logic [15:0] IMG_W_RST    = 16'd1024;
  localparam logic [15:0] IMG_H_RST    = 16'd768;
  localparam logic [9:0]  ITER_LIM_RST = 10'd150;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_ITER_LIMIT   = 2'd2
  } cfg_idx_e;

  // Configuration as seen by the front and back parts.
  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [9:0]  iteration_limit;
  } cfg_t;

  // Front part: coordinate mapping with a bit-serial divider.
  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } front_state_e;

  // Back part: iteration of z = z*z + c.
  typedef enum logic [1:0] {
    BE_IDLE,
    BE_MUL,
    BE_UPD,
    BE_DONE
  } back_state_e;

endpackage

### rtl/core/mandel_if.sv
// Valid/ready channel interfaces for pixel items and result items.
// Depends on mandel_pkg for the field widths.
interface mandel_pix_if;
  import mandel_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mandel_res_if;
  import mandel_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] escape_count;
  logic             inside_set;

  modport source (output valid, output escape_count, output inside_set, input ready);
  modport sink (input valid, input escape_count, input inside_set, output ready);
endinterface

### rtl/core/mandelbrot_escape_time_pixel_top.sv
// Mandelbrot escape-time pixel evaluator. Mapping a pixel item runs a bit-serial divider
// (one divider bit per cycle). The loop runs P passes, each a slice-serial multiply over
// NCH = ceil((FRAC_BITS+5)/17) slices and an update step; P is the escape count, plus one
// more pass for a point that escapes. Mapping overlaps the loop through the queue.
// Reset is asynchronous, active low: registers return to 1024/768/150, no item held.
module mandelbrot_escape_time_pixel_top #(
  parameter int FRAC_BITS   = mandel_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = mandel_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mandel_pix_if.sink                       pix_i,
  mandel_res_if.source                     res_o,
  input  logic                             cfg_we_i,
  input  logic [mandel_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mandel_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import mandel_pkg::*;

  localparam int Z_W = FRAC_BITS + 5;

  logic [15:0] img_w_q, img_h_q;
  logic [9:0]  iter_lim_q;
  cfg_t        cfg;

  logic                  fe_valid, fe_ready;
  logic signed [Z_W-1:0] fe_re, fe_im;
  logic                  be_valid, be_ready;
  logic [2*Z_W-1:0]      be_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q    <= IMG_W_RST;
      img_h_q    <= IMG_H_RST;
      iter_lim_q <= ITER_LIM_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IMAGE_WIDTH) begin
        img_w_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == CFG_IMAGE_HEIGHT) begin
        img_h_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == CFG_ITER_LIMIT) begin
        iter_lim_q <= cfg_wdata_i[9:0];
      end
    end
  end

  assign cfg.image_width     = img_w_q;
  assign cfg.image_height    = img_h_q;
  assign cfg.iteration_limit = iter_lim_q;

  mandel_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .pix_i      (pix_i),
    .pt_valid_o (fe_valid),
    .pt_ready_i (fe_ready),
    .c_re_o     (fe_re),
    .c_im_o     (fe_im)
  );

  mandel_queue #(
    .WIDTH (2 * Z_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fe_valid),
    .in_ready_o  (fe_ready),
    .in_data_i   ({fe_re, fe_im}),
    .out_valid_o (be_valid),
    .out_ready_i (be_ready),
    .out_data_o  (be_data)
  );

  mandel_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .pt_valid_i (be_valid),
    .pt_ready_o (be_ready),
    .c_re_i     ($signed(be_data[2*Z_W-1:Z_W])),
    .c_im_i     ($signed(be_data[Z_W-1:0])),
    .res_o      (res_o)
  );

endmodule

### rtl/core/mandel_front.sv
// Front part: accepts a pixel item and maps it to the complex point c.
// Both axes run a restoring divider in parallel, one quotient bit per cycle.
// Depends on mandel_pkg and mandel_if.
module mandel_front #(
  parameter int FRAC_BITS = mandel_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mandel_pkg::cfg_t          cfg_i,
  mandel_pix_if.sink                pix_i,
  output logic                      pt_valid_o,
  input  logic                      pt_ready_i,
  output logic signed [FRAC_BITS+4:0] c_re_o,
  output logic signed [FRAC_BITS+4:0] c_im_o
);
  import mandel_pkg::*;

  localparam int Z_W   = FRAC_BITS + 5;
  localparam int Q_W   = FRAC_BITS + 2;
  localparam int M_W   = FRAC_BITS + 3;
  localparam int STEPS = FRAC_BITS + 2;
  localparam int S_W   = $clog2(STEPS);
  localparam logic [M_W-1:0] SAT_MAG = {3'b100, {FRAC_BITS{1'b0}}};

  front_state_e state_q, state_d;
  logic [S_W-1:0] step_q;

  // Per-axis divider state: lane 0 is x, lane 1 is y.
  logic [15:0]    rem_q  [2];
  logic [Q_W-1:0] quo_q  [2];
  logic           nlsb_q [2];
  logic           neg_q  [2];
  logic           zero_q [2];
  logic           sat_q  [2];

  logic [15:0]    pos     [2];
  logic [15:0]    ctr     [2];
  logic [17:0]    diff    [2];
  logic [17:0]    absd    [2];
  logic [16:0]    mag_in  [2];
  logic           bit_in  [2];
  logic [16:0]    trial   [2];
  logic           ge      [2];
  logic [16:0]    rem_nx  [2];
  logic [M_W-1:0] mag_out [2];
  logic [Z_W-1:0] ext     [2];
  logic [Z_W-1:0] cval    [2];

  // Offset from the center, its magnitude, and one divider step per lane.
  always_comb begin
    pos[0] = pix_i.pixel_x;
    pos[1] = pix_i.pixel_y;
    ctr[0] = cfg_i.image_width;
    ctr[1] = cfg_i.image_height;
    for (int l = 0; l < 2; l++) begin
      diff[l]   = {1'b0, pos[l], 1'b0} - {2'b00, ctr[l]};
      absd[l]   = diff[l][17] ? (18'd0 - diff[l]) : diff[l];
      mag_in[l] = absd[l][16:0];
      bit_in[l] = (step_q == '0) ? nlsb_q[l] : 1'b0;
      trial[l]  = {rem_q[l], bit_in[l]};
      ge[l]     = trial[l] >= {1'b0, cfg_i.image_width};
      rem_nx[l] = ge[l] ? (trial[l] - {1'b0, cfg_i.image_width}) : trial[l];
      // Zero offset maps to zero; a far offset saturates to four.
      mag_out[l] = zero_q[l] ? '0 : (sat_q[l] ? SAT_MAG : {1'b0, quo_q[l]});
      ext[l]     = Z_W'(mag_out[l]);
      cval[l]    = neg_q[l] ? (Z_W'(0) - ext[l]) : ext[l];
    end
  end

  assign c_re_o = cval[0];
  assign c_im_o = cval[1];

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FE_DIV) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_d     = state_q;
    pix_i.ready = 1'b0;
    pt_valid_o  = 1'b0;
    case (state_q)
      FE_IDLE: begin
        pix_i.ready = 1'b1;
        if (pix_i.valid) begin
          state_d = FE_DIV;
        end
      end
      FE_DIV: begin
        if (step_q == S_W'(STEPS - 1)) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        pt_valid_o = 1'b1;
        if (pt_ready_i) begin
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  // Divider datapath: load on accept, shift in one quotient bit per step.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (state_q == FE_IDLE && pix_i.valid) begin
        rem_q[l]  <= mag_in[l][16:1];
        nlsb_q[l] <= mag_in[l][0];
        neg_q[l]  <= diff[l][17];
        zero_q[l] <= (mag_in[l] == '0);
        sat_q[l]  <= (mag_in[l] >= {cfg_i.image_width, 1'b0});
      end else if (state_q == FE_DIV) begin
        rem_q[l] <= rem_nx[l][15:0];
        quo_q[l] <= {quo_q[l][Q_W-2:0], ge[l]};
      end
    end
  end

endmodule

### rtl/core/mandel_queue.sv
// Short first-in first-out queue that parts the front from the back.
// Register storage with a single read address; depends on mandel_pkg for the default depth.
module mandel_queue #(
  parameter int WIDTH = 66,
  parameter int DEPTH = mandel_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);
  localparam int P_W = $clog2(DEPTH);
  localparam int C_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [P_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [C_W-1:0]   cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != C_W'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == P_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == P_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

### rtl/core/mandel_back.sv
// Back part: iterates z = z*z + c and holds the finished result item.
// Three products share a slice-serial multiply, then one update step.
// Depends on mandel_pkg and mandel_if.
module mandel_back #(
  parameter int FRAC_BITS = mandel_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mandel_pkg::cfg_t            cfg_i,
  input  logic                        pt_valid_i,
  output logic                        pt_ready_o,
  input  logic signed [FRAC_BITS+4:0] c_re_i,
  input  logic signed [FRAC_BITS+4:0] c_im_i,
  mandel_res_if.source                res_o
);
  import mandel_pkg::*;

  localparam int Z_W  = FRAC_BITS + 5;
  localparam int D    = MUL_DIGIT;
  localparam int NCH  = (Z_W + D - 1) / D;
  localparam int B_W  = NCH * D;
  localparam int P_W  = 2 * Z_W;
  localparam int PR_W = Z_W + D + 1;
  localparam int J_W  = $clog2(NCH);
  localparam int SQ_W = P_W - FRAC_BITS;
  localparam logic [SQ_W:0] FOUR = (SQ_W + 1)'(4) << FRAC_BITS;

  back_state_e state_q, state_d;
  logic [J_W-1:0]          j_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    in_set_q;
  logic signed [Z_W-1:0]   zr_q, zi_q, cre_q, cim_q;
  logic [B_W-1:0]          br_q, bi_q;
  logic signed [P_W-1:0]   acc_rr_q, acc_ii_q, acc_ri_q;
  logic                    res_valid_q;
  logic [CNT_W-1:0]        res_cnt_q;
  logic                    res_in_q;

  logic                    top_chunk, last_chunk, slot_free;
  logic signed [D:0]       cr, ci;
  logic signed [PR_W-1:0]  p_rr, p_ii, p_ri;
  logic signed [P_W-1:0]   acc_rr_nx, acc_ii_nx, acc_ri_nx;
  logic [SQ_W-1:0]         sr, si;
  logic [SQ_W:0]           mag2;
  logic                    escape;
  logic signed [Z_W-1:0]   nr, ni;
  logic [CNT_W-1:0]        cnt_inc;

  // Slice of the second factor, most significant first; only the top one is signed.
  assign top_chunk  = (j_q == '0);
  assign last_chunk = (j_q == J_W'(NCH - 1));
  assign cr = {top_chunk & br_q[B_W-1], br_q[B_W-1 -: D]};
  assign ci = {top_chunk & bi_q[B_W-1], bi_q[B_W-1 -: D]};

  // Partial products, accumulated by shift and add.
  assign p_rr = zr_q * cr;
  assign p_ii = zi_q * ci;
  assign p_ri = zr_q * ci;
  assign acc_rr_nx = top_chunk ? P_W'(p_rr) : (acc_rr_q <<< D) + P_W'(p_rr);
  assign acc_ii_nx = top_chunk ? P_W'(p_ii) : (acc_ii_q <<< D) + P_W'(p_ii);
  assign acc_ri_nx = top_chunk ? P_W'(p_ri) : (acc_ri_q <<< D) + P_W'(p_ri);

  // Update step: truncated squares, escape test and the next z.
  // The cross term 2*zr*zi is the product shifted by one bit less.
  assign sr      = acc_rr_q[P_W-1:FRAC_BITS];
  assign si      = acc_ii_q[P_W-1:FRAC_BITS];
  assign mag2    = {1'b0, sr} + {1'b0, si};
  assign escape  = (mag2 >= FOUR);
  assign nr      = $signed(acc_rr_q[FRAC_BITS+Z_W-1:FRAC_BITS])
                 - $signed(acc_ii_q[FRAC_BITS+Z_W-1:FRAC_BITS]) + cre_q;
  assign ni      = $signed(acc_ri_q[FRAC_BITS+Z_W-2:FRAC_BITS-1]) + cim_q;
  assign cnt_inc = cnt_q + 1'b1;

  assign slot_free = !res_valid_q || res_o.ready;
  assign pt_ready_o = (state_q == BE_IDLE);

  // State register and the slice counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BE_MUL && !last_chunk) begin
        j_q <= j_q + 1'b1;
      end else begin
        j_q <= '0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BE_IDLE: begin
        if (pt_valid_i) begin
          state_d = (cfg_i.iteration_limit == '0) ? BE_DONE : BE_MUL;
        end
      end
      BE_MUL: begin
        if (last_chunk) begin
          state_d = BE_UPD;
        end
      end
      BE_UPD: begin
        if (escape || cnt_inc >= cfg_i.iteration_limit) begin
          state_d = BE_DONE;
        end else begin
          state_d = BE_MUL;
        end
      end
      BE_DONE: begin
        if (slot_free) begin
          state_d = BE_IDLE;
        end
      end
      default: state_d = BE_IDLE;
    endcase
  end

  // Iteration datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      BE_IDLE: begin
        if (pt_valid_i) begin
          cre_q    <= c_re_i;
          cim_q    <= c_im_i;
          zr_q     <= '0;
          zi_q     <= '0;
          br_q     <= '0;
          bi_q     <= '0;
          cnt_q    <= '0;
          in_set_q <= 1'b1;
        end
      end
      BE_MUL: begin
        acc_rr_q <= acc_rr_nx;
        acc_ii_q <= acc_ii_nx;
        acc_ri_q <= acc_ri_nx;
        br_q     <= br_q << D;
        bi_q     <= bi_q << D;
      end
      BE_UPD: begin
        if (escape) begin
          in_set_q <= 1'b0;
        end else begin
          zr_q     <= nr;
          zi_q     <= ni;
          br_q     <= B_W'(nr);
          bi_q     <= B_W'(ni);
          cnt_q    <= cnt_inc;
          in_set_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: the next item iterates while a result waits here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (state_q == BE_DONE && slot_free) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BE_DONE && slot_free) begin
      res_cnt_q <= cnt_q;
      res_in_q  <= in_set_q;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.escape_count = res_cnt_q;
  assign res_o.inside_set   = res_in_q;

endmodule

### rtl/core/mandel_checker.sv
// Port-level checks for the Mandelbrot pixel block, bound to the top level.
// Depends on mandel_pkg; watches only the top-level ports.
module mandel_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [mandel_pkg::CNT_W-1:0]     out_count_i,
  input logic                             out_inside_i,
  input logic                             cfg_we_i,
  input logic [mandel_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [mandel_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import mandel_pkg::*;

  logic [9:0] lim_q;
  logic [7:0] pend_q, pend_d;
  logic       dirty_q, dirty_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Items in flight, and whether the configuration was written while any was in flight.
  always_comb begin
    pend_d  = pend_q + {7'd0, in_acc} - {7'd0, out_acc};
    dirty_d = (pend_d == '0) ? 1'b0 : (dirty_q || (cfg_we_i && pend_q != '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q   <= ITER_LIM_RST;
      pend_q  <= '0;
      dirty_q <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      dirty_q <= dirty_d;
      if (cfg_we_i && cfg_idx_i == CFG_ITER_LIMIT) begin
        lim_q <= cfg_wdata_i[9:0];
      end
    end
  end

  // A waiting result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  // A waiting result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_count_i) && $stable(out_inside_i))
    else $error("result payload changed while stalled");

  // A point inside the set used the whole limit; an escaped one stopped short.
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !dirty_q |->
      (out_inside_i ? (out_count_i == lim_q) : (out_count_i < lim_q)))
    else $error("escape count does not agree with inside flag and limit");

  // No result without an accepted pixel item behind it.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != '0)
    else $error("result offered with no pixel item in flight");

endmodule

bind mandelbrot_escape_time_pixel_top mandel_checker u_mandel_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (pix_i.valid),
  .in_ready_i   (pix_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_count_i  (res_o.escape_count),
  .out_inside_i (res_o.inside_set),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i),
  .cfg_wdata_i  (cfg_wdata_i)
);
